// ===== hdl/quantized_dot_product_u2_pack_defines.svh =====
// Assertion macros shared by the quantized dot-product RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef QUANTIZED_DOT_PRODUCT_U2_PACK_DEFINES_SVH
`define QUANTIZED_DOT_PRODUCT_U2_PACK_DEFINES_SVH

`ifndef SYNTHESIS

// pre in one cycle implies post in the next cycle
`define QDP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

// pre implies post in the same cycle
`define QDP_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

`else

`define QDP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`define QDP_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== hdl/qdp_pkg.sv =====
// Shared types and constants for the quantized dot-product block.
// No dependencies; imported by every module of the block.
package qdp_pkg;

    localparam int LANES    = 4;
    localparam int ACC_W    = 32;
    localparam int ACT_W    = 8;
    localparam int WGT_W    = 8;
    localparam int QNT_W    = 2;
    localparam int SHIFT_W  = 5;
    localparam int MULT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int TDATA_W  = 104;
    localparam int TUSER_W  = 3;
    localparam int OUT_W    = 8;

    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_LOAD  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHIFT = 2'd0,
        REG_MULT  = 2'd1,
        REG_RELU  = 2'd2,
        REG_BN    = 2'd3
    } t_reg_idx;

    // per-lane control from the sequencer
    typedef struct packed {
        logic acc_en;  // add activation * weight
        logic fin;     // last element: capture sum, clear accumulator
        logic load;    // write scale and offset
        logic mul_en;  // run the scaling multiply
    } t_lane_ctrl;

    // quantization settings seen by every lane
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [MULT_W-1:0]  mult;
        logic               relu;
        logic               bn;
    } t_quant_cfg;

    typedef logic [QNT_W-1:0] t_lane_q [LANES];

endpackage

// ===== hdl/quantized_dot_product_u2_pack.sv =====
// Top level of the four-lane quantized dot product with 2-bit packed output.
// Depends on qdp_pkg, qdp_lane, qdp_pack and the shared assertion header.
//
//  channel   direction  data                               handshake
//  s_axis    in         tdata/tuser/tlast request          tvalid/tready
//  m_axis    out        tdata packed byte                  tvalid/tready
//  cfg       in         i_cfg_idx / i_cfg_wdata            i_cfg_we
//
// Accumulate and load requests are taken one per cycle while s_axis_tready is
// high. A request with tlast closes the dot product: the accepting edge captures
// the sum into r_sum, the r_s1 stage runs the scaling multiply into r_prod, and
// the r_s2 stage quantizes and packs the byte into the output register.
// The input holds off while r_s1 or r_s2 is set, including any time the finished
// byte waits on a full output register.
// Reset (synchronous, active low) clears accumulators, scale/offset stores, the
// shift, ReLU and BN settings (mult resets to 1), the finish pipeline and the output valid.
`include "quantized_dot_product_u2_pack_defines.svh"

module quantized_dot_product_u2_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // cfg write port
    input  logic                          i_cfg_we,
    input  logic [qdp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [qdp_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, low to high: activation[7:0], weight_lane0..3 (8 each),
    // scale_k[31:0], offset_lambda[31:0]
    input  logic [qdp_pkg::TDATA_W-1:0]   s_axis_tdata,
    // tuser, low to high: command, lane_select[1:0]
    input  logic [qdp_pkg::TUSER_W-1:0]   s_axis_tuser,
    input  logic                          s_axis_tlast,
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: packed_result[7:0]
    output logic [qdp_pkg::OUT_W-1:0]     m_axis_tdata
);
    import qdp_pkg::*;

    localparam int WGT_LSB   = ACT_W;
    localparam int SCALE_LSB = ACT_W + LANES*WGT_W;
    localparam int OFF_LSB   = SCALE_LSB + ACC_W;

    // configuration registers
    logic [SHIFT_W-1:0] r_shift;
    logic [MULT_W-1:0]  r_mult;
    logic               r_relu;
    logic               r_bn;

    // finish pipeline: r_s1 = multiply running, r_s2 = byte waiting to pack
    logic r_s1;
    logic r_s2;

    logic       w_accept;
    logic       w_is_load;
    logic       w_fin;
    logic [1:0] w_sel;
    logic       w_pack_ready;
    logic       w_pack_take;

    t_quant_cfg w_cfg;
    t_lane_ctrl w_ctrl [LANES];
    t_lane_q    w_q;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_mult  <= MULT_W'(1);
            r_relu  <= 1'b0;
            r_bn    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SHIFT: r_shift <= i_cfg_wdata[SHIFT_W-1:0];
                REG_MULT:  r_mult  <= i_cfg_wdata[MULT_W-1:0];
                REG_RELU:  r_relu  <= i_cfg_wdata[0];
                REG_BN:    r_bn    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_cfg = '{shift: r_shift, mult: r_mult, relu: r_relu, bn: r_bn};

    // hold off new requests while a finish is in flight
    assign s_axis_tready = !r_s1 && !r_s2;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_load     = (t_cmd'(s_axis_tuser[0]) == CMD_LOAD);
    assign w_sel         = s_axis_tuser[2:1];
    assign w_fin         = w_accept && !w_is_load && s_axis_tlast;
    assign w_pack_take   = r_s2 && w_pack_ready;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_ctrl[i].acc_en = w_accept && !w_is_load;
            w_ctrl[i].fin    = w_fin;
            w_ctrl[i].load   = w_accept && w_is_load && (w_sel == 2'(i));
            w_ctrl[i].mul_en = r_s1;
        end
    end

    // advance the finish pipeline; drop r_s2 once the merge stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
        end else begin
            r_s1 <= w_fin;
            if (r_s1) begin
                r_s2 <= 1'b1;
            end else if (w_pack_take) begin
                r_s2 <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        qdp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl[g]),
            .i_cfg    (w_cfg),
            .i_act    (s_axis_tdata[ACT_W-1:0]),
            .i_wgt    ($signed(s_axis_tdata[WGT_LSB + g*WGT_W +: WGT_W])),
            .i_scale  (s_axis_tdata[SCALE_LSB +: ACC_W]),
            .i_offset (s_axis_tdata[OFF_LSB +: ACC_W]),
            .o_q      (w_q[g])
        );
    end

    qdp_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_s2),
        .i_q     (w_q),
        .o_ready (w_pack_ready),
        .o_valid (m_axis_tvalid),
        .i_take  (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    // a closing request starts the multiply and stalls the input
    `QDP_ASSERT_NEXT(a_fin_starts_mul, i_clk, i_rst_n, w_fin, r_s1 && !s_axis_tready, "stall lost")
    // the multiply always hands over to the pack stage
    `QDP_ASSERT_NEXT(a_mul_to_pack, i_clk, i_rst_n, r_s1, r_s2, "multiply result lost")
    // only one finish in flight at a time
    `QDP_ASSERT_SAME(a_one_in_flight, i_clk, i_rst_n, r_s1, !r_s2, "two finishes in flight")

endmodule

// ===== hdl/qdp_lane.sv =====
// One multiply-accumulate lane with its scale/offset store and quantizer.
// Depends on qdp_pkg.
module qdp_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  qdp_pkg::t_lane_ctrl       i_ctrl,
    input  qdp_pkg::t_quant_cfg       i_cfg,
    input  logic [qdp_pkg::ACT_W-1:0] i_act,
    input  logic signed [qdp_pkg::WGT_W-1:0] i_wgt,
    input  logic [qdp_pkg::ACC_W-1:0] i_scale,
    input  logic [qdp_pkg::ACC_W-1:0] i_offset,
    output logic [qdp_pkg::QNT_W-1:0] o_q
);
    import qdp_pkg::*;

    localparam int PROD_W = ACT_W + WGT_W + 1;

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] r_scale;
    logic [ACC_W-1:0] r_offset;
    logic [ACC_W-1:0] r_sum;
    logic [ACC_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_mac;
    logic [ACC_W-1:0] w_factor;
    logic [ACC_W-1:0] w_scaled;
    logic [ACC_W-1:0] w_biased;
    logic signed [ACC_W-1:0] w_shifted;
    logic w_bn_mode;

    assign w_mac = $signed({1'b0, i_act}) * i_wgt;
    assign n_acc = r_acc + ACC_W'(w_mac);

    assign w_bn_mode = i_cfg.relu & i_cfg.bn;

    always_comb begin
        if (w_bn_mode) begin
            w_factor = r_scale;
        end else if (i_cfg.relu) begin
            w_factor = {{(ACC_W-MULT_W){1'b0}}, i_cfg.mult};
        end else begin
            w_factor = {{(ACC_W-1){1'b0}}, 1'b1};
        end
    end

    // low word of the product only; wraps like the accumulator
    assign w_scaled = w_factor * r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_scale  <= '0;
            r_offset <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_scale  <= i_scale;
                r_offset <= i_offset;
            end
            if (i_ctrl.fin) begin
                r_acc <= '0;
            end else if (i_ctrl.acc_en) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin) begin
            r_sum <= n_acc;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_scaled;
        end
    end

    assign w_biased  = r_prod + (w_bn_mode ? r_offset : '0);
    assign w_shifted = $signed(w_biased) >>> i_cfg.shift;

    // clip to 0..3
    always_comb begin
        if (w_shifted[ACC_W-1]) begin
            o_q = '0;
        end else if (|w_shifted[ACC_W-2:QNT_W]) begin
            o_q = '1;
        end else begin
            o_q = w_shifted[QNT_W-1:0];
        end
    end

endmodule

// ===== hdl/qdp_pack.sv =====
// Merge stage: packs the lane codes into one byte and holds it for the output.
// Depends on qdp_pkg.
module qdp_pack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  qdp_pkg::t_lane_q          i_q,
    output logic                      o_ready,
    output logic                      o_valid,
    input  logic                      i_take,
    output logic [qdp_pkg::OUT_W-1:0] o_data
);
    import qdp_pkg::*;

    logic             r_valid;
    logic [OUT_W-1:0] r_data;
    logic [OUT_W-1:0] w_packed;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_packed[i*QNT_W +: QNT_W] = i_q[i];
        end
    end

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_data <= w_packed;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
